[design/jse_pkg.sv]
package jse_pkg;

  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 16'd256;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam int IDX_W = 3;

  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] HEX_ALPHA_LO = 8'h37;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_ENCODE  = 1'b1;

  typedef enum logic [1:0] {
    JOB_PASS  = 2'd0,
    JOB_SHORT = 2'd1,
    JOB_UNI   = 2'd2,
    JOB_OVF   = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       valid;
    logic       last;
    logic       ovf;
  } out_word_t;

  typedef struct packed {
    logic not_empty;
    job_t head;
  } q_status_t;

  function automatic logic [IDX_W-1:0] job_len(input job_kind_t kind);
    logic [IDX_W-1:0] len;
    unique case (kind)
      JOB_PASS:  len = 3'd1;
      JOB_SHORT: len = 3'd2;
      JOB_UNI:   len = 3'd6;
      JOB_OVF:   len = 3'd1;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

[design/jse_front.sv]
module jse_front #(
  parameter int SPACE_WIDTH = 16,
  parameter int MIN_RESERVE = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [jse_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_req_type,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_string,
  input  logic                         q_full,
  output logic                         q_push,
  output jse_pkg::job_t                q_job
);

  localparam int EXT_W  = (SPACE_WIDTH > jse_pkg::CFG_W) ? SPACE_WIDTH : jse_pkg::CFG_W;
  localparam int NEED_W = 4;

  logic [jse_pkg::CFG_W-1:0] cfg_r;
  logic [SPACE_WIDTH-1:0]    space_r, space_nxt;
  logic                      aborted_r, aborted_nxt;

  logic [jse_pkg::CFG_W-1:0] bs_m1;
  logic [EXT_W-1:0]          bs_ext, space_max;
  logic [SPACE_WIDTH-1:0]    restart_space;
  logic [7:0]                letter;
  jse_pkg::job_kind_t        kind;
  logic [jse_pkg::IDX_W-1:0] len;
  logic [NEED_W-1:0]         need;
  logic                      no_room;
  logic                      accept;

  function automatic logic [7:0] short_escape(input logic [7:0] b);
    logic [7:0] c;
    unique case (b)
      8'h22:   c = jse_pkg::CH_QUOTE;
      8'h5C:   c = jse_pkg::CH_BSLASH;
      8'h2F:   c = jse_pkg::CH_SLASH;
      8'h08:   c = 8'h62;
      8'h0C:   c = 8'h66;
      8'h0A:   c = 8'h6E;
      8'h0D:   c = 8'h72;
      8'h09:   c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // restart value: size minus one, held at zero, saturated to the counter width
  always_comb begin
    bs_m1         = (cfg_r == '0) ? '0 : cfg_r - 1'b1;
    bs_ext        = EXT_W'(bs_m1);
    space_max     = EXT_W'({SPACE_WIDTH{1'b1}});
    restart_space = (bs_ext > space_max) ? space_max[SPACE_WIDTH-1:0]
                                         : bs_ext[SPACE_WIDTH-1:0];
  end

  always_comb begin
    letter = short_escape(in_data_byte);
    if (letter != 8'h00) begin
      kind = jse_pkg::JOB_SHORT;
    end else if (in_data_byte >= jse_pkg::CH_SPACE) begin
      kind = jse_pkg::JOB_PASS;
    end else begin
      kind = jse_pkg::JOB_UNI;
    end
    len     = jse_pkg::job_len(kind);
    need    = NEED_W'(len) + NEED_W'(MIN_RESERVE);
    no_room = space_r < SPACE_WIDTH'(need);
  end

  always_comb begin
    space_nxt   = space_r;
    aborted_nxt = aborted_r;
    q_push      = 1'b0;
    q_job.kind  = kind;
    q_job.data  = (kind == jse_pkg::JOB_SHORT) ? letter : in_data_byte;
    if (accept) begin
      if (in_req_type == jse_pkg::REQ_RESTART) begin
        space_nxt   = restart_space;
        aborted_nxt = 1'b0;
      end else begin
        if (!aborted_r) begin
          q_push = 1'b1;
          if (no_room) begin
            q_job.kind  = jse_pkg::JOB_OVF;
            aborted_nxt = 1'b1;
          end else begin
            space_nxt = space_r - SPACE_WIDTH'(len);
          end
        end
        // end of string drops the abort regardless of this word
        if (in_end_of_string) begin
          aborted_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= jse_pkg::CFG_RESET;
      space_r   <= SPACE_WIDTH'(jse_pkg::CFG_RESET - 1'b1);
      aborted_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      space_r   <= space_nxt;
      aborted_r <= aborted_nxt;
    end
  end

endmodule

[design/jse_queue.sv]
module jse_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jse_pkg::job_t      push_job,
  output logic               full,
  input  logic               pop,
  output jse_pkg::q_status_t status
);

  jse_pkg::job_t                 slots_r [jse_pkg::Q_DEPTH];
  logic [jse_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [jse_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full             = (cnt_r == jse_pkg::Q_CNT_W'(jse_pkg::Q_DEPTH));
  assign status.not_empty = (cnt_r != '0);
  assign status.head      = slots_r[rd_ptr_r];
  assign do_push          = push && !full;
  assign do_pop           = pop && status.not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/jse_back.sv]
module jse_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jse_pkg::q_status_t  q_status,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output jse_pkg::out_word_t  out_word
);

  logic [jse_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      full_r, full_nxt;
  jse_pkg::out_word_t        word_r, word_nxt;
  logic                      can_load, load;
  logic [jse_pkg::IDX_W-1:0] len;
  logic                      is_last;
  jse_pkg::job_t             job;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'(jse_pkg::CH_ZERO + 8'(nib))
                         : 8'(jse_pkg::HEX_ALPHA_LO + 8'(nib));
  endfunction

  assign job      = q_status.head;
  assign can_load = !full_r || out_pop;
  assign load     = can_load && q_status.not_empty;
  assign len      = jse_pkg::job_len(job.kind);
  assign is_last  = (idx_r == len - 1'b1);
  assign q_pop    = load && is_last;

  always_comb begin
    word_nxt.byte_val = 8'h00;
    word_nxt.valid    = 1'b1;
    word_nxt.last     = is_last;
    word_nxt.ovf      = 1'b0;
    unique case (job.kind)
      jse_pkg::JOB_PASS: begin
        word_nxt.byte_val = job.data;
      end
      jse_pkg::JOB_SHORT: begin
        word_nxt.byte_val = (idx_r == '0) ? jse_pkg::CH_BSLASH : job.data;
      end
      jse_pkg::JOB_UNI: begin
        unique case (idx_r)
          3'd0:    word_nxt.byte_val = jse_pkg::CH_BSLASH;
          3'd1:    word_nxt.byte_val = jse_pkg::CH_U;
          3'd4:    word_nxt.byte_val = hex_char(job.data[7:4]);
          3'd5:    word_nxt.byte_val = hex_char(job.data[3:0]);
          default: word_nxt.byte_val = jse_pkg::CH_ZERO;
        endcase
      end
      jse_pkg::JOB_OVF: begin
        word_nxt.valid = 1'b0;
        word_nxt.ovf   = 1'b1;
      end
      default: begin
        word_nxt.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    full_nxt = full_r;
    if (load) begin
      full_nxt = 1'b1;
      idx_nxt  = is_last ? '0 : idx_r + 1'b1;
    end else if (out_pop) begin
      full_nxt = 1'b0;
    end
  end

  assign out_empty = !full_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      full_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      full_r <= full_nxt;
    end
  end

  // mid-expansion the job must still sit at the head of the queue
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> q_status.not_empty)
    else $error("expansion index set with no job waiting");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> ((job.kind == jse_pkg::JOB_UNI) ||
                       (job.kind == jse_pkg::JOB_SHORT && idx_r == 3'd1)))
    else $error("expansion index beyond job length");

  a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && word_r.ovf) |-> (!word_r.valid && word_r.last && word_r.byte_val == 8'h00))
    else $error("overflow word malformed");

endmodule

[design/json_string_escaper_top.sv]
// An accepted word is written into the job queue and then registered in the
// back end's output word, from which its first output byte can be popped.
// Throughput: one pass-through input word per cycle while the queue has room;
// a short escape gives 2 bytes, a unicode escape 6, one byte a cycle while popped.
// A four-entry job queue lets the input side run ahead of the expansion.
// Reset (rst_n low, synchronous): queues empty, buffer size 256, space 255, no abort.
module json_string_escaper_top #(
  parameter int SPACE_WIDTH = 16,
  parameter int MIN_RESERVE = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [jse_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_req_type,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_string,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_byte,
  output logic                      out_valid,
  output logic                      out_last,
  output logic                      out_overflow
);

  logic               q_full, q_push, q_pop;
  jse_pkg::job_t      q_job;
  jse_pkg::q_status_t q_status;
  jse_pkg::out_word_t out_word;

  jse_front #(
    .SPACE_WIDTH (SPACE_WIDTH),
    .MIN_RESERVE (MIN_RESERVE)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_job)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .status   (q_status)
  );

  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  assign out_byte     = out_word.byte_val;
  assign out_valid    = out_word.valid;
  assign out_last     = out_word.last;
  assign out_overflow = out_word.ovf;

endmodule
